// ===== hw/rtl/lrd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_pkg
// Types, codes and the CRC-32 byte step shared by the log record deframer.
// ----------------------------------------------------------------------------
package lrd_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	typedef enum logic [2:0] {
		PH_OP   = 3'd0,
		PH_KLEN = 3'd1,
		PH_KEY  = 3'd2,
		PH_VLEN = 3'd3,
		PH_VAL  = 3'd4,
		PH_CRC  = 3'd5
	} phase_t;

	localparam logic [1:0] KIND_OP      = 2'd0;
	localparam logic [1:0] KIND_KEY     = 2'd1;
	localparam logic [1:0] KIND_VAL     = 2'd2;
	localparam logic [1:0] KIND_VERDICT = 2'd3;

	localparam logic [1:0] V_GOOD  = 2'd0;
	localparam logic [1:0] V_BAD   = 2'd1;
	localparam logic [1:0] V_TRUNC = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] verdict;
		logic       rec_end;
	} item_t;

	// up to two result items per input word
	typedef struct packed {
		logic [1:0] n;
		item_t      item0;
		item_t      item1;
	} push_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lrd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_core
// Record parser state, running CRC and the result items for one log word.
// ----------------------------------------------------------------------------
module lrd_core
	import lrd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] log_byte,
	input  wire logic       is_last,
	input  wire logic       order,
	output push_t           push
);

	phase_t      phase_q, phase_d;
	logic [1:0]  wcnt_q, wcnt_d;
	logic [31:0] wasm_q, wasm_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] crc_q, crc_d;
	logic        halted_q, halted_d;

	logic [31:0] crc_upd;
	logic [31:0] asm_next;
	logic        word_done;
	logic [31:0] rem_dec;
	logic        crc_ok;
	item_t       res0, res1;
	logic [1:0]  n;

	always_comb begin
		crc_upd   = crc_byte(crc_q, log_byte);
		if (order) begin
			asm_next = {wasm_q[23:0], log_byte};
		end else begin
			asm_next = wasm_q | ({24'd0, log_byte} << {wcnt_q, 3'b000});
		end
		word_done = (wcnt_q == 2'd3);
		rem_dec   = rem_q - 32'd1;
		crc_ok    = (asm_next == ~crc_q);
	end

	always_comb begin
		phase_d  = phase_q;
		wcnt_d   = wcnt_q;
		wasm_d   = wasm_q;
		rem_d    = rem_q;
		crc_d    = crc_q;
		halted_d = halted_q;
		res0     = '0;
		res1     = '0;
		n        = 2'd0;
		if (step && !halted_q) begin
			unique case (phase_q)
				PH_KLEN, PH_VLEN: begin
					crc_d = crc_upd;
					if (word_done) begin
						rem_d  = asm_next;
						wcnt_d = 2'd0;
						wasm_d = '0;
						if (phase_q == PH_KLEN) begin
							phase_d = (asm_next == 32'd0) ? PH_VLEN : PH_KEY;
						end else begin
							phase_d = (asm_next == 32'd0) ? PH_CRC : PH_VAL;
						end
					end else begin
						wcnt_d = wcnt_q + 2'd1;
						wasm_d = asm_next;
					end
				end
				PH_KEY, PH_VAL: begin
					crc_d     = crc_upd;
					res0.kind = (phase_q == PH_KEY) ? KIND_KEY : KIND_VAL;
					res0.data = log_byte;
					n         = 2'd1;
					rem_d     = rem_dec;
					if (rem_dec == 32'd0) begin
						phase_d = (phase_q == PH_KEY) ? PH_VLEN : PH_CRC;
						wcnt_d  = 2'd0;
						wasm_d  = '0;
					end
				end
				PH_CRC: begin
					if (word_done) begin
						res0.kind    = KIND_VERDICT;
						res0.verdict = crc_ok ? V_GOOD : V_BAD;
						res0.rec_end = 1'b1;
						n            = 2'd1;
						crc_d        = CRC_INIT;
						phase_d      = PH_OP;
						wcnt_d       = 2'd0;
						wasm_d       = '0;
						halted_d     = !crc_ok;
					end else begin
						wcnt_d = wcnt_q + 2'd1;
						wasm_d = asm_next;
					end
				end
				default: begin
					crc_d     = crc_byte(CRC_INIT, log_byte);
					res0.kind = KIND_OP;
					res0.data = log_byte;
					n         = 2'd1;
					phase_d   = PH_KLEN;
					wcnt_d    = 2'd0;
					wasm_d    = '0;
					rem_d     = '0;
				end
			endcase
			// end of log inside a record: close it as truncated
			if (is_last && !(phase_q == PH_CRC && word_done)) begin
				res1.kind    = KIND_VERDICT;
				res1.verdict = V_TRUNC;
				res1.rec_end = 1'b1;
				halted_d     = 1'b1;
				if (n == 2'd0) begin
					res0 = res1;
					n    = 2'd1;
				end else begin
					n = 2'd2;
				end
			end
		end
		push.n     = n;
		push.item0 = res0;
		push.item1 = res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OP;
			wcnt_q   <= '0;
			wasm_q   <= '0;
			rem_q    <= '0;
			crc_q    <= CRC_INIT;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			wcnt_q   <= wcnt_d;
			wasm_q   <= wasm_d;
			rem_q    <= rem_d;
			crc_q    <= crc_d;
			halted_q <= halted_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/lrd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_fifo
// Four-entry result queue taking up to two items and giving one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module lrd_fifo
	import lrd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output item_t      head
);

	item_t      mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] wr_ptr1;

	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= 3'd2);
	assign head      = mem_q[rd_ptr_q];
	assign wr_ptr1   = wr_ptr_q + 2'd1;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.item0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr1] <= push.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.n;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push.n} - {2'd0, pop};
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/log_record_deframer_crc32.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// log_record_deframer_crc32
// Splits a write-ahead-log byte stream into op, key and value words and
// closes each record with a CRC-32 verdict.
// ----------------------------------------------------------------------------
// One log word is taken per cycle while the output queue has room. A word
// enters an input register; the parser and CRC update run on it once the
// queue has room and write their result items into a four-entry output
// queue that registers them for the output port. A word yields at most two
// items (a byte item followed by a truncation verdict); the input stalls
// while the queue has fewer than two free entries, so the sustained rate is
// set by the output port at one item per cycle. The byte order register is
// written through the cfg port, which is always ready.
module log_record_deframer_crc32
	import lrd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       word_byte_order,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] log_byte,
	input  wire logic       is_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      item_kind,
	output logic [7:0]      item_byte,
	output logic [1:0]      verdict,
	output logic            record_end
);

	logic       order_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room;
	logic       fire;
	push_t      push;
	item_t      head;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && room;
	assign in_ready  = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				order_q <= word_byte_order;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// hold the payload until the parser takes it
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= log_byte;
			last_s1 <= is_last;
		end
	end

	lrd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (fire),
		.log_byte (byte_s1),
		.is_last  (last_s1),
		.order    (order_q),
		.push     (push)
	);

	lrd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign item_kind  = head.kind;
	assign item_byte  = head.data;
	assign verdict    = head.verdict;
	assign record_end = head.rec_end;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives write-ahead-log records through the deframer with random idling on
// both sides, predicts every op, key, value and verdict word on the fly, and
// checks each output word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import lrd_pkg::*;

	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS   = 40;

	// ways to end the run on a halting record
	localparam int HALT_MISMATCH = 0;
	localparam int HALT_CUT      = 1;
	localparam int HALT_HUGE_KEY = 2;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       word_byte_order;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] log_byte;
	logic       is_last;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] item_kind;
	logic [7:0] item_byte;
	logic [1:0] verdict;
	logic       record_end;

	// predicted deframer state
	phase_t      exp_phase;
	logic [1:0]  exp_count;
	logic [31:0] exp_word;
	logic [31:0] exp_remain;
	logic [31:0] exp_crc;
	logic        exp_halted;
	logic        exp_order;
	item_t       pending_items[$];

	// record under construction
	logic [7:0]  frame[$];
	logic [31:0] frame_crc;

	int   bytes_sent   = 0;
	int   errors       = 0;
	int   tx_idle_pct  = 15;
	int   rx_stall_pct = 15;
	logic calm         = 1'b0;
	logic rx_hold_req  = 1'b0;

	log_record_deframer_crc32 u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.word_byte_order (word_byte_order),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.log_byte        (log_byte),
		.is_last         (is_last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.item_kind       (item_kind),
		.item_byte       (item_byte),
		.verdict         (verdict),
		.record_end      (record_end)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_top failed");
		$finish;
	end

	function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void push_item(input logic [1:0] kind, input logic [7:0] data,
			input logic [1:0] verd, input logic fin);
		item_t it;
		it.kind    = kind;
		it.data    = data;
		it.verdict = verd;
		it.rec_end = fin;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// returns 1 once the fourth byte of a length or CRC word is in
	function automatic logic gather_word_byte(input logic [7:0] b);
		if (exp_order) begin
			exp_word = {exp_word[23:0], b};
		end else begin
			exp_word = exp_word | ({24'd0, b} << (8 * exp_count));
		end
		exp_count = exp_count + 2'd1;
		return exp_count == 2'd0;
	endfunction

	function automatic void begin_word(input phase_t next);
		exp_phase = next;
		exp_count = 2'd0;
		exp_word  = 32'd0;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b, input logic last);
		logic ok;
		if (exp_halted) begin
			return;
		end
		case (exp_phase)
			PH_KLEN, PH_VLEN: begin
				exp_crc = crc32_next(exp_crc, b);
				if (gather_word_byte(b)) begin
					exp_remain = exp_word;
					if (exp_phase == PH_KLEN) begin
						if (exp_remain == 32'd0) exp_phase = PH_VLEN;
						else exp_phase = PH_KEY;
					end else begin
						if (exp_remain == 32'd0) exp_phase = PH_CRC;
						else exp_phase = PH_VAL;
					end
					exp_count = 2'd0;
					exp_word  = 32'd0;
				end
			end
			PH_KEY, PH_VAL: begin
				exp_crc = crc32_next(exp_crc, b);
				push_item((exp_phase == PH_KEY) ? KIND_KEY : KIND_VAL, b, V_GOOD, 1'b0);
				exp_remain = exp_remain - 32'd1;
				if (exp_remain == 32'd0) begin
					if (exp_phase == PH_KEY) begin_word(PH_VLEN);
					else begin_word(PH_CRC);
				end
			end
			PH_CRC: begin
				if (gather_word_byte(b)) begin
					ok = (exp_word == ~exp_crc);
					push_item(KIND_VERDICT, 8'h00, ok ? V_GOOD : V_BAD, 1'b1);
					exp_crc = CRC_INIT;
					begin_word(PH_OP);
					if (!ok) begin
						exp_halted = 1'b1;
					end
					return;
				end
			end
			default: begin
				exp_crc = crc32_next(CRC_INIT, b);
				push_item(KIND_OP, b, V_GOOD, 1'b0);
				begin_word(PH_KLEN);
				exp_remain = 32'd0;
			end
		endcase
		if (last) begin
			push_item(KIND_VERDICT, 8'h00, V_TRUNC, 1'b1);
			exp_halted = 1'b1;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < MAX_REPORTS) begin
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		end
		errors++;
	endtask

	always @(posedge clk) begin : check_items
		item_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_items.size() == 0) begin
				report_mismatch("word with nothing expected",
					32'({item_kind, item_byte}), 32'd0);
			end else begin
				want = pending_items.pop_front();
				if (item_kind !== want.kind) begin
					report_mismatch("item_kind", 32'(item_kind), 32'(want.kind));
				end
				if (item_byte !== want.data) begin
					report_mismatch("item_byte", 32'(item_byte), 32'(want.data));
				end
				if (verdict !== want.verdict) begin
					report_mismatch("verdict", 32'(verdict), 32'(want.verdict));
				end
				if (record_end !== want.rec_end) begin
					report_mismatch("record_end", 32'(record_end), 32'(want.rec_end));
				end
			end
		end
	end

	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				// long hold: let the output queue fill and stall the input
				rx_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		log_byte <= b;
		is_last  <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b, last);
		bytes_sent++;
		if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// stop offering, wait for every predicted word, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_items.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_byte_order(input logic order);
		drain();
		cfg_valid       <= 1'b1;
		word_byte_order <= order;
		do @(posedge clk); while (!cfg_ready);
		exp_order = order;
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_byte(input logic [7:0] b);
		frame.insert(frame.size(), b);
		frame_crc = crc32_next(frame_crc, b);
	endfunction

	function automatic void add_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++) begin
			add_byte(exp_order ? w[8 * (3 - k) +: 8] : w[8 * k +: 8]);
		end
	endfunction

	// fill < 0 gives random bytes
	function automatic void build_frame(input logic [7:0] op, input int unsigned klen,
			input int unsigned vlen, input int key_fill, input int val_fill, input logic bad);
		logic [31:0] w;
		frame.delete();
		frame_crc = CRC_INIT;
		add_byte(op);
		add_word(klen);
		repeat (klen) add_byte((key_fill < 0) ? 8'($urandom_range(0, 255)) : 8'(key_fill));
		add_word(vlen);
		repeat (vlen) add_byte((val_fill < 0) ? 8'($urandom_range(0, 255)) : 8'(val_fill));
		w = ~frame_crc;
		if (bad) begin
			w = w ^ (32'd1 << $urandom_range(0, 31));
		end
		add_word(w);
	endfunction

	task automatic send_frame(input int upto, input logic last_flag);
		for (int i = 0; i <= upto; i++) begin
			send_byte(frame[i], last_flag && (i == upto));
		end
	endtask

	function automatic int unsigned pick_len();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2) return 0;
		if (r < 8) return $urandom_range(1, 6);
		if (r == 8) return $urandom_range(7, 24);
		return $urandom_range(25, 40);
	endfunction

	task automatic send_random_record();
		build_frame(8'($urandom_range(0, 255)), pick_len(), pick_len(), -1, -1, 1'b0);
		send_frame(frame.size() - 1, $urandom_range(0, 5) == 0);
	endtask

	task automatic test_directed_frames();
		set_byte_order(1'b0);
		// empty key and value: both length words skip straight ahead
		build_frame(8'h00, 0, 0, -1, -1, 1'b0);
		send_frame(frame.size() - 1, 1'b0);
		set_byte_order(1'b1);
		// end of log on the last CRC byte closes the record but does not halt
		build_frame(8'hFF, 1, 1, 8'hFF, 8'h00, 1'b0);
		send_frame(frame.size() - 1, 1'b1);
	endtask

	task automatic test_random_frames();
		int budget;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0) set_byte_order(1'b0);
			else if (ph == 1) set_byte_order(1'b1);
			else set_byte_order(1'($urandom_range(0, 1)));
			tx_idle_pct  = (ph % 3) * 20;
			rx_stall_pct = ((ph + 1) % 3) * 20;
			budget = bytes_sent + 140;
			while (bytes_sent < budget) send_random_record();
		end
	endtask

	task automatic test_output_backpressure();
		set_byte_order(1'($urandom_range(0, 1)));
		tx_idle_pct = 0;
		rx_hold_req = 1'b1;
		repeat (6) send_random_record();
		drain();
		tx_idle_pct  = 20;
		rx_stall_pct = 20;
		repeat (4) send_random_record();
	endtask

	task automatic test_steady_stream();
		int budget;
		calm = 1'b1;
		set_byte_order(!exp_order);
		budget = bytes_sent + 200;
		while (bytes_sent < budget) send_random_record();
	endtask

	task automatic test_halting_frame();
		int sel;
		sel = $urandom_range(HALT_MISMATCH, HALT_HUGE_KEY);
		if (sel == HALT_MISMATCH) begin
			build_frame(8'($urandom_range(0, 255)), pick_len(), pick_len(), -1, -1, 1'b1);
			send_frame(frame.size() - 1, 1'($urandom_range(0, 1)));
		end else if (sel == HALT_CUT) begin
			// end of log anywhere before the last CRC byte
			build_frame(8'($urandom_range(0, 255)), pick_len(), pick_len(), -1, -1, 1'b0);
			send_frame($urandom_range(0, frame.size() - 2), 1'b1);
		end else begin
			frame.delete();
			frame_crc = CRC_INIT;
			add_byte(8'($urandom_range(0, 255)));
			add_word(32'hFFFF_FFFF);
			repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
			send_frame(frame.size() - 1, 1'b1);
		end
		// halted: every further word is dropped
		repeat (20) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n          <= 1'b0;
		cfg_valid       <= 1'b0;
		word_byte_order <= 1'b0;
		in_valid        <= 1'b0;
		log_byte        <= 8'h00;
		is_last         <= 1'b0;
		exp_phase  = PH_OP;
		exp_count  = 2'd0;
		exp_word   = 32'd0;
		exp_remain = 32'd0;
		exp_crc    = CRC_INIT;
		exp_halted = 1'b0;
		exp_order  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_random_frames();
		test_output_backpressure();
		test_steady_stream();
		test_halting_frame();

		drain();
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
